@@ design/gpum_pkg.sv @@
`default_nettype none

package gpum_pkg;

    localparam int MV_W   = 18;
    localparam int REF_W  = 5;
    localparam int DIR_W  = 2;
    localparam int QIDX_W = 3;
    localparam int REG_W  = 2;
    localparam int SEEN_W = 3;
    localparam int CFG_W  = 3;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;

    typedef logic signed [MV_W-1:0]  t_mv;
    typedef logic signed [REF_W-1:0] t_ref;
    typedef logic [DIR_W-1:0]        t_dir;

    localparam t_dir DIR_NONE = 2'd0;
    localparam t_dir DIR_L0   = 2'd1;
    localparam t_dir DIR_L1   = 2'd2;
    localparam t_dir DIR_BI   = 2'd3;

    localparam t_ref REF_NONE = '1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [REG_W-1:0] REGION_FIRST  = 2'd0;
    localparam logic [REG_W-1:0] REGION_SECOND = 2'd1;
    localparam logic [REG_W-1:0] REGION_EDGE   = 2'd2;

    localparam logic [SEEN_W-1:0] SEEN_MAX        = 3'd7;
    localparam logic [CFG_W-1:0]  MAX_CANDS_RESET = 3'd6;

    // input tdata layout, lowest field last
    typedef struct packed {
        logic [3:0]        pad;
        logic [REG_W-1:0]  region_kind;
        logic [QIDX_W-1:0] part_b_index;
        logic [QIDX_W-1:0] part_a_index;
        t_ref              ref_l1;
        t_mv               mv_l1_y;
        t_mv               mv_l1_x;
        t_ref              ref_l0;
        t_mv               mv_l0_y;
        t_mv               mv_l0_x;
        t_dir              dir_in;
    } t_s_data;

    typedef struct packed {
        logic first_of_list;
        logic req_type;
    } t_s_user;

    // one uni-prediction list entry: a single list's motion
    typedef struct packed {
        logic use_l1;
        t_ref ref_idx;
        t_mv  mv_y;
        t_mv  mv_x;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_mv  mv1y;
        t_mv  mv1x;
        t_mv  mv0y;
        t_mv  mv0x;
        t_ref ref1;
        t_ref ref0;
        t_dir dir;
    } t_motion;

    localparam int MOTION_W = $bits(t_motion);
    localparam int M_PAD_W  = M_TDATA_W - MOTION_W;

endpackage

`default_nettype wire

@@ design/gpum_ram.sv @@
`default_nettype none

module gpum_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/gpum_select.sv @@
`default_nettype none

module gpum_select (
    input  wire logic                          i_ok_a,
    input  wire gpum_pkg::t_entry              i_ent_a,
    input  wire logic                          i_ok_b,
    input  wire gpum_pkg::t_entry              i_ent_b,
    input  wire logic [gpum_pkg::REG_W-1:0]    i_region,
    output gpum_pkg::t_motion                  o_motion
);

    import gpum_pkg::*;

    t_motion ma;
    t_motion mb;
    t_motion mc;

    // expand a stored entry; entries past the fill count read as empty
    always_comb begin
        ma = '{dir: DIR_NONE, ref0: REF_NONE, ref1: REF_NONE,
               mv0x: '0, mv0y: '0, mv1x: '0, mv1y: '0};
        mb = ma;
        if (i_ok_a) begin
            if (i_ent_a.use_l1) begin
                ma.dir  = DIR_L1;
                ma.ref1 = i_ent_a.ref_idx;
                ma.mv1x = i_ent_a.mv_x;
                ma.mv1y = i_ent_a.mv_y;
            end else begin
                ma.dir  = DIR_L0;
                ma.ref0 = i_ent_a.ref_idx;
                ma.mv0x = i_ent_a.mv_x;
                ma.mv0y = i_ent_a.mv_y;
            end
        end
        if (i_ok_b) begin
            if (i_ent_b.use_l1) begin
                mb.dir  = DIR_L1;
                mb.ref1 = i_ent_b.ref_idx;
                mb.mv1x = i_ent_b.mv_x;
                mb.mv1y = i_ent_b.mv_y;
            end else begin
                mb.dir  = DIR_L0;
                mb.ref0 = i_ent_b.ref_idx;
                mb.mv0x = i_ent_b.mv_x;
                mb.mv0y = i_ent_b.mv_y;
            end
        end
    end

    // blended edge motion
    always_comb begin
        mc = '{dir: DIR_NONE, ref0: REF_NONE, ref1: REF_NONE,
               mv0x: '0, mv0y: '0, mv1x: '0, mv1y: '0};
        if (ma.dir == DIR_L0 && mb.dir == DIR_L1) begin
            mc.dir  = DIR_BI;
            mc.ref0 = ma.ref0;
            mc.mv0x = ma.mv0x;
            mc.mv0y = ma.mv0y;
            mc.ref1 = mb.ref1;
            mc.mv1x = mb.mv1x;
            mc.mv1y = mb.mv1y;
        end else if (ma.dir == DIR_L1 && mb.dir == DIR_L0) begin
            mc.dir  = DIR_BI;
            mc.ref0 = mb.ref0;
            mc.mv0x = mb.mv0x;
            mc.mv0y = mb.mv0y;
            mc.ref1 = ma.ref1;
            mc.mv1x = ma.mv1x;
            mc.mv1y = ma.mv1y;
        end else if (ma.dir == DIR_L0 && mb.dir == DIR_L0) begin
            mc.dir  = DIR_L0;
            mc.ref0 = mb.ref0;
            mc.mv0x = mb.mv0x;
            mc.mv0y = mb.mv0y;
        end else if (ma.dir == DIR_L1 && mb.dir == DIR_L1) begin
            mc.dir  = DIR_L1;
            mc.ref1 = mb.ref1;
            mc.mv1x = mb.mv1x;
            mc.mv1y = mb.mv1y;
        end
    end

    always_comb begin
        case (i_region)
            REGION_FIRST: o_motion = ma;
            REGION_EDGE:  o_motion = mc;
            default:      o_motion = mb;
        endcase
    end

endmodule

`default_nettype wire

@@ design/geo_partition_uni_merge_and_motion_store.sv @@
// Channel    Dir  Signals                               Carries
// s_axis     in   tvalid/tready/tdata[95:0]/tuser[1:0]  load candidate or motion query
// m_axis     out  tvalid/tready/tdata[87:0]             motion for one query
// cfg        in   i_cfg_we/i_cfg_wdata[2:0]             max_regular_cands
//
// One transfer per cycle unless a query stalls on the output. A query is held in the input
// register, then its result in the result register. Loads give no result.
// Query reads use two copies of the list memory, addressed at input transfer time.
// Reset (synchronous, i_rst_n low) empties the list through its fill count; no clearing pass.
// A query waiting on a full result register stalls the input; loads never wait on the output.
`default_nettype none

module geo_partition_uni_merge_and_motion_store #(
    parameter int UNI_LIST_DEPTH = 6
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gpum_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // dir_in, mv_l0_x, mv_l0_y, ref_l0, mv_l1_x, mv_l1_y, ref_l1,
    // part_a_index, part_b_index, region_kind, zero pad
    input  wire logic [gpum_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type, first_of_list
    input  wire logic [gpum_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_dir, out_ref_l0, out_ref_l1, out_mv_l0_x, out_mv_l0_y,
    // out_mv_l1_x, out_mv_l1_y, zero pad
    output logic [gpum_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    import gpum_pkg::*;

    localparam int IDX_W = $clog2(UNI_LIST_DEPTH);
    localparam int CNT_W = $clog2(UNI_LIST_DEPTH + 1);
    localparam int CMP_W = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;

    logic [CFG_W-1:0]  r_max_cands;
    logic [SEEN_W-1:0] r_seen;
    logic [CNT_W-1:0]  r_count;

    logic    r_in_valid;
    t_s_data r_in_data;
    t_s_user r_in_user;
    t_s_data in_data;

    logic r_byp_hit_a;
    logic r_byp_hit_b;
    t_entry r_byp_word;

    logic    r_out_valid;
    t_motion r_out;

    logic is_query;
    logic advance;
    logic in_fire;

    logic [SEEN_W-1:0] eff_seen;
    logic [CNT_W-1:0]  eff_count;
    logic              load_take;
    logic              load_add;
    logic              parity;
    logic              use_l1;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_entry;
    logic [SEEN_W-1:0] n_seen;
    logic [CNT_W-1:0]  n_count;

    logic [ENTRY_W-1:0] ram_a_q;
    logic [ENTRY_W-1:0] ram_b_q;
    t_entry  ent_a;
    t_entry  ent_b;
    logic    ok_a;
    logic    ok_b;
    t_motion sel_motion;

    assign in_data = t_s_data'(s_axis_tdata);

    assign is_query      = (r_in_user.req_type == REQ_QUERY);
    assign advance       = r_in_valid && (!is_query || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // list build for a load in the input register
    always_comb begin
        eff_seen  = r_in_user.first_of_list ? '0 : r_seen;
        eff_count = r_in_user.first_of_list ? '0 : r_count;
        load_take = (eff_seen < r_max_cands) && (eff_count < CNT_W'(UNI_LIST_DEPTH));
        load_add  = load_take && (r_in_data.dir_in != DIR_NONE);
        parity    = eff_seen[0];
        // even positions prefer L0, odd prefer L1; fall back to the other list
        use_l1    = r_in_data.dir_in[parity] ? parity : ~parity;

        wr_en            = advance && !is_query && load_add;
        wr_addr          = eff_count[IDX_W-1:0];
        wr_entry.use_l1  = use_l1;
        wr_entry.ref_idx = use_l1 ? r_in_data.ref_l1 : r_in_data.ref_l0;
        wr_entry.mv_x    = use_l1 ? r_in_data.mv_l1_x : r_in_data.mv_l0_x;
        wr_entry.mv_y    = use_l1 ? r_in_data.mv_l1_y : r_in_data.mv_l0_y;

        n_seen = eff_seen;
        if (load_take) begin
            n_seen = (eff_seen == SEEN_MAX) ? SEEN_MAX : eff_seen + 1'b1;
        end
        n_count = load_add ? eff_count + 1'b1 : eff_count;
    end

    gpum_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (UNI_LIST_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_re    (in_fire),
        .i_raddr (in_data.part_a_index[IDX_W-1:0]),
        .o_rdata (ram_a_q)
    );

    gpum_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (UNI_LIST_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_re    (in_fire),
        .i_raddr (in_data.part_b_index[IDX_W-1:0]),
        .o_rdata (ram_b_q)
    );

    // a load written in the same cycle as the read is forwarded
    assign ent_a = r_byp_hit_a ? r_byp_word : t_entry'(ram_a_q);
    assign ent_b = r_byp_hit_b ? r_byp_word : t_entry'(ram_b_q);
    assign ok_a  = CMP_W'(r_in_data.part_a_index) < CMP_W'(r_count);
    assign ok_b  = CMP_W'(r_in_data.part_b_index) < CMP_W'(r_count);

    gpum_select u_select (
        .i_ok_a   (ok_a),
        .i_ent_a  (ent_a),
        .i_ok_b   (ok_b),
        .i_ent_b  (ent_b),
        .i_region (r_in_data.region_kind),
        .o_motion (sel_motion)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cands <= MAX_CANDS_RESET;
            r_seen      <= '0;
            r_count     <= '0;
            r_in_valid  <= 1'b0;
            r_byp_hit_a <= 1'b0;
            r_byp_hit_b <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_cands <= i_cfg_wdata;
            end
            if (advance && !is_query) begin
                r_seen  <= n_seen;
                r_count <= n_count;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (in_fire) begin
                r_byp_hit_a <= wr_en && (wr_addr == in_data.part_a_index[IDX_W-1:0]);
                r_byp_hit_b <= wr_en && (wr_addr == in_data.part_b_index[IDX_W-1:0]);
            end
            if (advance && is_query) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data  <= in_data;
            r_in_user  <= t_s_user'(s_axis_tuser);
            r_byp_word <= wr_entry;
        end
        if (advance && is_query) begin
            r_out <= sel_motion;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out};

endmodule

`default_nettype wire

@@ design/gpum_checker.sv @@
`default_nettype none

module gpum_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_cfg_we,
    input wire logic [gpum_pkg::CFG_W-1:0]     i_cfg_wdata,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [gpum_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input wire logic [gpum_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [gpum_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import gpum_pkg::*;

    t_motion mo;

    assign mo = t_motion'(m_axis_tdata[MOTION_W-1:0]);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && mo.dir == DIR_NONE |->
            mo.ref0 == REF_NONE && mo.ref1 == REF_NONE && mo.mv0x == '0 && mo.mv0y == '0
            && mo.mv1x == '0 && mo.mv1y == '0)
        else $error("empty motion carries data");

    a_l0_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && mo.dir == DIR_L0 |->
            mo.ref1 == REF_NONE && mo.mv1x == '0 && mo.mv1y == '0)
        else $error("L0 motion carries L1 data");

    a_l1_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && mo.dir == DIR_L1 |->
            mo.ref0 == REF_NONE && mo.mv0x == '0 && mo.mv0y == '0)
        else $error("L1 motion carries L0 data");

endmodule

bind geo_partition_uni_merge_and_motion_store gpum_checker u_gpum_checker (.*);

`default_nettype wire
